FILE: src/cvd_pkg.sv
// Package for the chained vibration driver: codes, constant tables and state type.
package cvd_pkg;

    localparam int PHASE_STEPS = 200;
    localparam int PHASE_W     = 8;
    localparam int AMP_W       = 7;
    localparam int UA_W        = 14;
    localparam int UB_W        = 13;
    localparam int UC_W        = 6;
    localparam int PROD_W      = 26;
    localparam int RECIP_SHIFT = 19;

    localparam logic [PHASE_W-1:0] HALF_STEPS = PHASE_W'(100);
    localparam logic [PHASE_W:0]   FULL_STEPS = (PHASE_W+1)'(200);
    localparam logic [UB_W-1:0]    RECIP_100  = UB_W'(5243);
    localparam logic [UC_W-1:0]    ROUND_HALF = UC_W'(50);
    localparam logic [AMP_W-1:0]   AMP_MAX    = AMP_W'(100);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DUTY = 2'd1;
    localparam logic [1:0] FS_FREQ = 2'd2;

    localparam logic [2:0] FREQ_RESET = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_FINISH,
        S_DONE
    } t_state;

    localparam logic [6:0] PERIOD_TABLE [8] = '{
        7'd85, 7'd72, 7'd60, 7'd52, 7'd44, 7'd37, 7'd32, 7'd27
    };

    localparam logic [6:0] DUTY_PCT [32] = '{
        7'd0,  7'd3,  7'd6,  7'd10, 7'd13, 7'd16, 7'd19, 7'd22,
        7'd26, 7'd29, 7'd32, 7'd35, 7'd38, 7'd42, 7'd45, 7'd48,
        7'd51, 7'd54, 7'd57, 7'd61, 7'd64, 7'd67, 7'd70, 7'd73,
        7'd77, 7'd80, 7'd83, 7'd86, 7'd89, 7'd93, 7'd96, 7'd99
    };

    localparam logic [3:0] DUTY_LVL [32] = '{
        4'd0,  4'd0,  4'd0,  4'd1,  4'd2,  4'd2,  4'd3,  4'd3,
        4'd4,  4'd4,  4'd5,  4'd5,  4'd6,  4'd6,  4'd7,  4'd7,
        4'd8,  4'd8,  4'd9,  4'd9,  4'd10, 4'd10, 4'd11, 4'd11,
        4'd12, 4'd12, 4'd13, 4'd13, 4'd14, 4'd14, 4'd15, 4'd15
    };

    localparam logic [6:0] SINE_ROM [100] = '{
        7'd0,  7'd3,  7'd6,  7'd10, 7'd13, 7'd16, 7'd19, 7'd22, 7'd25, 7'd28,
        7'd31, 7'd34, 7'd37, 7'd40, 7'd43, 7'd46, 7'd49, 7'd51, 7'd54, 7'd57,
        7'd59, 7'd62, 7'd64, 7'd67, 7'd69, 7'd71, 7'd73, 7'd76, 7'd78, 7'd80,
        7'd81, 7'd83, 7'd85, 7'd87, 7'd88, 7'd90, 7'd91, 7'd92, 7'd93, 7'd95,
        7'd95, 7'd96, 7'd97, 7'd98, 7'd98, 7'd99, 7'd99, 7'd100, 7'd100, 7'd100,
        7'd100, 7'd100, 7'd100, 7'd99, 7'd99, 7'd98, 7'd98, 7'd97, 7'd96, 7'd95,
        7'd95, 7'd93, 7'd92, 7'd91, 7'd90, 7'd88, 7'd87, 7'd85, 7'd83, 7'd81,
        7'd80, 7'd78, 7'd76, 7'd73, 7'd71, 7'd69, 7'd67, 7'd64, 7'd62, 7'd59,
        7'd57, 7'd54, 7'd51, 7'd49, 7'd46, 7'd43, 7'd40, 7'd37, 7'd34, 7'd31,
        7'd28, 7'd25, 7'd22, 7'd19, 7'd16, 7'd13, 7'd10, 7'd6,  7'd3,  7'd0
    };

endpackage

FILE: src/chained_vibration_driver.sv
// Daisy-chained vibration actuator node: byte router, frame decoder and PWM envelope.
//
// Input stream: s_axis_tuser = 0 carries a received serial byte in s_axis_tdata,
// s_axis_tuser = 1 is a PWM period tick (tdata ignored). Every transaction gives
// exactly one output transaction with the forwarded byte (m_axis_tuser = 1 when
// it must go downstream) and the current drive status.
// A byte, or a tick while stopped, goes from acceptance straight to the done state,
// which loads the output register, and the input is ready again after that. A tick
// while running first passes through the multiply, divide and finish states:
// one multiply-add unit with a reciprocal multiply for the divide by 100 is
// stepped four times by the sequencer (envelope times duty, divide, period times
// amplitude, divide), then the finish state updates the bridge state and PWM hold.
// s_axis_tready is high only while the sequencer is idle, so one transaction is
// in flight at a time; the next may be accepted while the previous result still
// waits in the output register.
// If the receiver stalls, the result is held in the output register; a finished
// computation waits in its final state until that register frees up.
// Reset (i_rst_n low, synchronous) stops the drive, clears the frame decoder,
// phase, duty and PWM hold, selects frequency entry 3 and drops m_axis_tvalid.
module chained_vibration_driver
    import cvd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] fwd_byte, [8] running, [15:9] period_value,
                                        // [25:16] pwm_value, [26] bridge_opposite,
                                        // [30:27] intensity_level, [31] zero
    output logic        m_axis_tuser    // [0] fwd_valid
);

    t_state               r_state, n_state;
    logic [1:0]           r_frame, n_frame;
    logic [4:0]           r_held, n_held;
    logic [6:0]           r_duty, n_duty;
    logic [3:0]           r_level, n_level;
    logic [2:0]           r_freq, n_freq;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic                 r_running, n_running;
    logic                 r_bridge, n_bridge;
    logic [9:0]           r_pwm, n_pwm;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic                 r_fwd_valid, n_fwd_valid;
    logic [7:0]           r_fwd_byte, n_fwd_byte;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_data, n_out_data;
    logic                 r_out_user, n_out_user;

    logic                 s_fire;
    logic                 out_free;
    logic                 load_out;
    logic                 unit_en;
    logic [UA_W-1:0]      u_a;
    logic [UB_W-1:0]      u_b;
    logic [UC_W-1:0]      u_c;
    logic [UA_W+UB_W-1:0] u_full;
    logic [PHASE_W:0]     phase_inc;
    logic [6:0]           sine_idx;
    logic [PHASE_W-1:0]   mirror;
    logic [AMP_W-1:0]     amp;
    logic [AMP_W-1:0]     h_val;
    logic                 on_win;
    logic [5:0]           addr;
    logic [5:0]           addr_dec;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = (s_axis_tuser && r_running) ? S_MUL1 : S_DONE;
                end
            end
            S_MUL1:   n_state = S_DIV1;
            S_DIV1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_DIV2;
            S_DIV2:   n_state = S_FINISH;
            S_FINISH: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // envelope index and amplitude taps
    always_comb begin
        mirror = PHASE_W'(FULL_STEPS - (PHASE_W+1)'(1) - {1'b0, r_phase});
        if (r_phase < HALF_STEPS) begin
            sine_idx = r_phase[6:0];
        end else if ({1'b0, r_phase} < FULL_STEPS) begin
            sine_idx = mirror[6:0];
        end else begin
            sine_idx = '0;
        end
        amp    = (r_prod[PROD_W-1:RECIP_SHIFT] > AMP_MAX) ? AMP_MAX
                                                            : r_prod[PROD_W-1:RECIP_SHIFT];
        h_val  = r_prod[PROD_W-1:RECIP_SHIFT];
        on_win = ({1'b0, r_phase} < {2'b00, r_duty})
              || ((r_phase >= HALF_STEPS)
                  && ({1'b0, r_phase} < ({1'b0, HALF_STEPS} + {2'b00, r_duty})));
    end

    // sequencer outputs: handshake and shared unit operands
    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unit_en       = 1'b0;
        u_a           = '0;
        u_b           = '0;
        u_c           = '0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_MUL1: begin
                unit_en = 1'b1;
                u_a     = UA_W'(SINE_ROM[sine_idx]);
                u_b     = UB_W'(r_duty);
                u_c     = ROUND_HALF;
            end
            S_DIV1, S_DIV2: begin
                unit_en = 1'b1;
                u_a     = r_prod[UA_W-1:0];
                u_b     = RECIP_100;
            end
            S_MUL2: begin
                unit_en = 1'b1;
                u_a     = UA_W'(PERIOD_TABLE[r_freq]);
                u_b     = UB_W'(amp);
                u_c     = ROUND_HALF;
            end
            S_FINISH: ;
            S_DONE:   load_out = out_free;
            default:  ;
        endcase
    end

    assign u_full    = ((UA_W+UB_W)'(u_a) * (UA_W+UB_W)'(u_b)) + (UA_W+UB_W)'(u_c);
    assign phase_inc = {1'b0, r_phase} + (PHASE_W+1)'(1);
    assign addr      = s_axis_tdata[6:1];
    assign addr_dec  = addr - 6'd1;

    // datapath next values
    always_comb begin
        n_frame     = r_frame;
        n_held      = r_held;
        n_duty      = r_duty;
        n_level     = r_level;
        n_freq      = r_freq;
        n_phase     = r_phase;
        n_running   = r_running;
        n_bridge    = r_bridge;
        n_pwm       = r_pwm;
        n_prod      = r_prod;
        n_fwd_valid = r_fwd_valid;
        n_fwd_byte  = r_fwd_byte;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (unit_en) begin
            n_prod = u_full[PROD_W-1:0];
        end

        if (s_fire) begin
            n_fwd_valid = 1'b0;
            n_fwd_byte  = '0;
            if (s_axis_tuser) begin
                if (r_running) begin
                    n_phase = (phase_inc >= (PHASE_W+1)'(PHASE_STEPS)) ? '0
                                                                       : phase_inc[PHASE_W-1:0];
                end
            end else if (!s_axis_tdata[7]) begin
                if (addr != 6'd0) begin
                    n_frame     = FS_IDLE;
                    n_fwd_valid = 1'b1;
                    n_fwd_byte  = {1'b0, addr_dec, s_axis_tdata[0]};
                end else if (!s_axis_tdata[0]) begin
                    n_frame   = FS_IDLE;
                    n_running = 1'b0;
                    n_duty    = '0;
                    n_level   = '0;
                end else begin
                    n_frame = FS_DUTY;
                end
            end else begin
                case (r_frame)
                    FS_IDLE: begin
                        n_fwd_valid = 1'b1;
                        n_fwd_byte  = s_axis_tdata;
                    end
                    FS_DUTY: begin
                        n_held  = s_axis_tdata[4:0];
                        n_frame = FS_FREQ;
                    end
                    FS_FREQ: begin
                        n_freq    = s_axis_tdata[2:0];
                        n_running = 1'b1;
                        n_duty    = DUTY_PCT[r_held];
                        n_level   = DUTY_LVL[r_held];
                        n_frame   = FS_IDLE;
                    end
                    default: n_frame = FS_IDLE;
                endcase
            end
        end

        if (r_state == S_FINISH) begin
            n_bridge = on_win;
            n_pwm    = on_win ? {1'b0, h_val, 2'b00} : 10'd1;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_user  = r_fwd_valid;
            n_out_data  = {1'b0, r_level, r_bridge, r_pwm, PERIOD_TABLE[r_freq],
                           r_running, r_fwd_byte};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame     <= FS_IDLE;
            r_held      <= '0;
            r_duty      <= '0;
            r_level     <= '0;
            r_freq      <= FREQ_RESET;
            r_phase     <= '0;
            r_running   <= 1'b0;
            r_bridge    <= 1'b0;
            r_pwm       <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_held      <= n_held;
            r_duty      <= n_duty;
            r_level     <= n_level;
            r_freq      <= n_freq;
            r_phase     <= n_phase;
            r_running   <= n_running;
            r_bridge    <= n_bridge;
            r_pwm       <= n_pwm;
            r_fwd_valid <= n_fwd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_fwd_byte <= n_fwd_byte;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
